FILE: rtl/core/ffpa_pkg.sv
// Package for the first-fit partition allocator.
// Holds request/response types, status codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package ffpa_pkg;

    // Command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic        command;
        logic [7:0]  job_id;
        logic [15:0] request_size;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] start_address;
    } t_rsp;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_FIN,
        S_DONE
    } t_state;

endpackage

FILE: rtl/core/ffpa_table.sv
// Segment table storage: one write port, one read port, registered read data.
// Depends on nothing; entry layout is packed by the sequencer.
`timescale 1ns / 1ps

module ffpa_table #(
    parameter int DEPTH = 16,
    parameter int EW    = 41
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [EW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [EW-1:0]            o_rdata
);
    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;

    // Write and read the table
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ffpa_ctrl.sv
// Sequencer for the first-fit partition allocator: scan, decide, shift, respond.
// Depends on ffpa_pkg; drives the table ports of ffpa_table.
`timescale 1ns / 1ps

module ffpa_ctrl #(
    parameter int MAX_SEGMENTS = 16,
    parameter int ADDRESS_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  ffpa_pkg::t_req                  i_req,
    output logic                            o_valid,
    input  logic                            i_stall,
    output ffpa_pkg::t_rsp                  o_rsp,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [15:0]                     i_cfg_data,
    output logic                            o_we,
    output logic [$clog2(MAX_SEGMENTS)-1:0] o_waddr,
    output logic [2*ADDRESS_BITS+8:0]       o_wdata,
    output logic                            o_re,
    output logic [$clog2(MAX_SEGMENTS)-1:0] o_raddr,
    input  logic [2*ADDRESS_BITS+8:0]       i_rdata
);
    import ffpa_pkg::*;

    localparam int AB  = ADDRESS_BITS;
    localparam int IW  = $clog2(MAX_SEGMENTS);
    localparam int CNW = $clog2(MAX_SEGMENTS + 1);
    localparam int CW  = (AB > 16) ? AB : 16;
    localparam logic [CNW-1:0] MaxCnt = CNW'(MAX_SEGMENTS);

    typedef struct packed {
        logic [AB-1:0] start;
        logic [AB-1:0] len;
        logic [7:0]    owner;
        logic          busy;
    } t_entry;

    t_state           r_state, n_state;
    logic [AB-1:0]    r_msize, n_msize;
    logic [CNW-1:0]   r_cnt, n_cnt;
    t_req             r_req, n_req;
    logic [CNW-1:0]   r_ptr, n_ptr;
    logic [CNW-1:0]   r_left, n_left;
    logic             r_desc, n_desc;
    logic [1:0]       r_delta, n_delta;
    logic             r_dv, n_dv;
    logic [IW-1:0]    r_didx, n_didx;
    logic             r_dup, n_dup;
    logic             r_hit, n_hit;
    logic [IW-1:0]    r_hidx, n_hidx;
    t_entry           r_hent, n_hent;
    t_entry           r_pent, n_pent;
    t_entry           r_nent, n_nent;
    t_entry           r_last, n_last;
    logic             r_hasprev, n_hasprev;
    logic             r_hasnext, n_hasnext;
    logic [2:0]       r_st, n_st;
    logic [15:0]      r_addr, n_addr;
    logic             r_ovalid, n_ovalid;
    t_rsp             r_orsp, n_orsp;

    t_entry           w_e;
    t_entry           w_wd;
    logic [CW-1:0]    w_size;
    logic             w_issue;
    logic             w_drained;
    logic             w_mn, w_mp;
    logic [CNW-1:0]   w_s;
    logic [CW-1:0]    w_hstart;

    assign w_e       = t_entry'(i_rdata);
    assign w_size    = CW'(r_req.request_size);
    assign w_issue   = (r_left != '0);
    assign w_drained = (r_left == '0) && !r_dv;
    assign w_mn      = r_hasnext && !r_nent.busy;
    assign w_mp      = r_hasprev && !r_pent.busy;
    assign w_s       = CNW'(r_hidx) + CNW'(1) + CNW'(w_mn);
    assign w_hstart  = CW'(r_hent.start);

    // Hold off requests while busy or while a configuration write is offered
    assign o_stall     = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_rsp       = r_orsp;
    assign o_re        = w_issue && (r_state == S_SCAN || r_state == S_SHIFT);
    assign o_raddr     = r_ptr[IW-1:0];
    assign o_wdata     = w_wd;

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:   n_state = S_IDLE;
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_state = S_INIT;
                end else if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_drained) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_req.command == CMD_ALLOC) begin
                    if (!r_dup && r_hit && r_req.request_size != '0 &&
                        CW'(r_hent.len) != w_size && r_cnt != MaxCnt) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = r_hit ? S_SHIFT : S_DONE;
                end
            end
            S_SHIFT: begin
                if (w_drained) begin
                    n_state = (r_req.command == CMD_ALLOC) ? S_FIN : S_DONE;
                end
            end
            S_FIN:    n_state = S_DONE;
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_INIT;
        endcase
    end

    // Datapath and table access
    always_comb begin
        n_msize   = r_msize;
        n_cnt     = r_cnt;
        n_req     = r_req;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_desc    = r_desc;
        n_delta   = r_delta;
        n_dv      = 1'b0;
        n_didx    = r_ptr[IW-1:0];
        n_dup     = r_dup;
        n_hit     = r_hit;
        n_hidx    = r_hidx;
        n_hent    = r_hent;
        n_pent    = r_pent;
        n_nent    = r_nent;
        n_last    = r_last;
        n_hasprev = r_hasprev;
        n_hasnext = r_hasnext;
        n_st      = r_st;
        n_addr    = r_addr;
        n_ovalid  = r_ovalid;
        n_orsp    = r_orsp;
        o_we      = 1'b0;
        o_waddr   = '0;
        w_wd      = '0;

        // Drop the output once taken
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        // Step the read pointer
        if ((r_state == S_SCAN || r_state == S_SHIFT) && w_issue) begin
            n_dv   = 1'b1;
            n_left = r_left - CNW'(1);
            n_ptr  = r_desc ? (r_ptr - CNW'(1)) : (r_ptr + CNW'(1));
        end

        case (r_state)
            S_INIT: begin
                o_we     = 1'b1;
                w_wd.len = r_msize;
                n_cnt    = CNW'(1);
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_msize = AB'(i_cfg_data);
                end else if (i_valid) begin
                    n_req     = i_req;
                    n_ptr     = '0;
                    n_left    = r_cnt;
                    n_desc    = 1'b0;
                    n_dup     = 1'b0;
                    n_hit     = 1'b0;
                    n_hasprev = 1'b0;
                    n_hasnext = 1'b0;
                end
            end
            S_SCAN: begin
                // Look for owner match and first fit
                if (r_dv) begin
                    n_last = w_e;
                    if (r_req.command == CMD_ALLOC) begin
                        if (w_e.busy && w_e.owner == r_req.job_id) begin
                            n_dup = 1'b1;
                        end
                        if (!r_hit && !w_e.busy && CW'(w_e.len) >= w_size) begin
                            n_hit  = 1'b1;
                            n_hidx = r_didx;
                            n_hent = w_e;
                        end
                    end else begin
                        if (!r_hit && w_e.busy && w_e.owner == r_req.job_id) begin
                            n_hit     = 1'b1;
                            n_hidx    = r_didx;
                            n_hent    = w_e;
                            n_pent    = r_last;
                            n_hasprev = (r_didx != '0);
                        end
                        if (r_hit && r_didx == IW'(r_hidx + IW'(1))) begin
                            n_nent    = w_e;
                            n_hasnext = 1'b1;
                        end
                    end
                end
            end
            S_DECIDE: begin
                n_addr = '0;
                if (r_req.command == CMD_ALLOC) begin
                    if (r_dup) begin
                        n_st = ST_DUPLICATE;
                    end else if (r_req.request_size == '0 || !r_hit) begin
                        n_st = ST_NO_FIT;
                    end else if (CW'(r_hent.len) == w_size) begin
                        o_we       = 1'b1;
                        o_waddr    = r_hidx;
                        w_wd       = r_hent;
                        w_wd.busy  = 1'b1;
                        w_wd.owner = r_req.job_id;
                        n_st       = ST_OK;
                        n_addr     = w_hstart[15:0];
                    end else if (r_cnt == MaxCnt) begin
                        n_st = ST_FULL;
                    end else begin
                        // Claim the low part; open a slot above it
                        o_we       = 1'b1;
                        o_waddr    = r_hidx;
                        w_wd.start = r_hent.start;
                        w_wd.len   = AB'(r_req.request_size);
                        w_wd.owner = r_req.job_id;
                        w_wd.busy  = 1'b1;
                        n_st       = ST_OK;
                        n_addr     = w_hstart[15:0];
                        n_cnt      = r_cnt + CNW'(1);
                        n_desc     = 1'b1;
                        n_ptr      = r_cnt - CNW'(1);
                        n_left     = r_cnt - CNW'(1) - CNW'(r_hidx);
                    end
                end else if (!r_hit) begin
                    n_st = ST_NOT_FOUND;
                end else begin
                    // Merge with free neighbors, then close the gap
                    o_we       = 1'b1;
                    o_waddr    = w_mp ? IW'(r_hidx - IW'(1)) : r_hidx;
                    w_wd.start = w_mp ? r_pent.start : r_hent.start;
                    w_wd.owner = r_hent.owner;
                    w_wd.busy  = 1'b0;
                    w_wd.len   = r_hent.len + (w_mp ? r_pent.len : AB'(0))
                               + (w_mn ? r_nent.len : AB'(0));
                    n_st       = ST_OK;
                    n_delta    = {w_mp & w_mn, w_mp ^ w_mn};
                    n_cnt      = r_cnt - CNW'(w_mp) - CNW'(w_mn);
                    n_desc     = 1'b0;
                    n_ptr      = w_s;
                    n_left     = (r_cnt > w_s) ? (r_cnt - w_s) : '0;
                end
            end
            S_SHIFT: begin
                if (r_dv) begin
                    o_we    = 1'b1;
                    w_wd    = w_e;
                    o_waddr = r_desc ? IW'(r_didx + IW'(1)) : IW'(r_didx - IW'(r_delta));
                end
            end
            S_FIN: begin
                // Write the free remainder above the claimed part
                o_we       = 1'b1;
                o_waddr    = IW'(r_hidx + IW'(1));
                w_wd.start = r_hent.start + AB'(r_req.request_size);
                w_wd.len   = r_hent.len - AB'(r_req.request_size);
                w_wd.owner = r_hent.owner;
                w_wd.busy  = 1'b0;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid             = 1'b1;
                    n_orsp.status        = r_st;
                    n_orsp.start_address = r_addr;
                end
            end
            default: begin
                n_cnt = CNW'(1);
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_msize  <= AB'(16'd4096);
            r_cnt    <= CNW'(1);
            r_left   <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_msize  <= n_msize;
            r_cnt    <= n_cnt;
            r_left   <= n_left;
            r_dv     <= n_dv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_ptr     <= n_ptr;
        r_desc    <= n_desc;
        r_delta   <= n_delta;
        r_didx    <= n_didx;
        r_dup     <= n_dup;
        r_hit     <= n_hit;
        r_hidx    <= n_hidx;
        r_hent    <= n_hent;
        r_pent    <= n_pent;
        r_nent    <= n_nent;
        r_last    <= n_last;
        r_hasprev <= n_hasprev;
        r_hasnext <= n_hasnext;
        r_st      <= n_st;
        r_addr    <= n_addr;
        r_orsp    <= n_orsp;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && (r_cnt <= MaxCnt))
        else $error("segment count out of range");

    a_write_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (CNW'(o_waddr) <= r_cnt))
        else $error("table write beyond live segments");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && i_stall) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !(r_ovalid && i_stall)) |=> (r_ovalid && r_state == S_IDLE))
        else $error("result not loaded on completion");

endmodule

FILE: rtl/core/first_fit_partition_allocator_unit.sv
// First-fit partition allocator: top level.
// Depends on ffpa_pkg, ffpa_table and ffpa_ctrl.
//
// Usage:
//   Request channel (i_valid / o_stall / i_req) carries allocate or release
//   commands; one response per request leaves on (o_valid / i_stall / o_rsp).
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
//   memory_size and resets the table to one free segment; requests are held
//   off while it is offered.
// Sequence, with N live segments:
//   scan reads all N entries (one table read per cycle, registered read data),
//   a decide step follows, a split allocate then shifts the entries above the
//   hit upward and writes the free remainder, a release shifts the entries
//   above the merged segment downward; then the response is loaded. The next
//   request can be taken once the response is loaded, since one request is
//   handled at a time.
// Reset and config: after reset or a memory_size write, the init state writes
//   entry 0 before requests are taken again.
// Stall: a stalled response waits in the output register; a next request may
//   still be taken and processed, and waits only to deliver its response.
`timescale 1ns / 1ps

module first_fit_partition_allocator_unit #(
    parameter int MAX_SEGMENTS = 16,
    parameter int ADDRESS_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ffpa_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output ffpa_pkg::t_rsp o_rsp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_data
);
    import ffpa_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int EW = 2 * ADDRESS_BITS + 9;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic          w_re;
    logic [IW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;

    // Sequencer
    ffpa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    // Segment table
    ffpa_table #(
        .DEPTH (MAX_SEGMENTS),
        .EW    (EW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

FILE: test/tb.sv
// Testbench for first_fit_partition_allocator_unit: random allocate/release traffic
// checked against a behavioral segment-table model held in a scoreboard class.
// Depends on ffpa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb;
    import ffpa_pkg::*;

    localparam int NSEG = 16;
    localparam int LAT  = 60;

    // Segment-table model and queue of expected responses
    class alloc_scoreboard;
        logic [15:0] mem_size;
        logic [15:0] seg_start [NSEG];
        logic [15:0] seg_len [NSEG];
        logic [7:0]  seg_owner [NSEG];
        bit          seg_busy [NSEG];
        int          seg_count;
        t_rsp        expected_rsp [$];
        int          errors;

        function void init_table(logic [15:0] size);
            mem_size = size;
            for (int i = 0; i < NSEG; i++) begin
                seg_start[i] = '0;
                seg_len[i] = '0;
                seg_owner[i] = '0;
                seg_busy[i] = 0;
            end
            seg_len[0] = size;
            seg_count = 1;
        endfunction

        function int find_job(logic [7:0] job);
            for (int i = 0; i < seg_count; i++) begin
                if (seg_busy[i] && seg_owner[i] == job) return i;
            end
            return -1;
        endfunction

        function void shift_down(int k);
            for (int i = k; i + 1 < seg_count; i++) begin
                seg_start[i] = seg_start[i+1];
                seg_len[i] = seg_len[i+1];
                seg_owner[i] = seg_owner[i+1];
                seg_busy[i] = seg_busy[i+1];
            end
            seg_count--;
        endfunction

        function t_rsp allocate(logic [7:0] job, logic [15:0] size);
            t_rsp r;
            r.status = ST_NO_FIT;
            r.start_address = '0;
            if (find_job(job) >= 0) begin
                r.status = ST_DUPLICATE;
                return r;
            end
            if (size == 0) return r;
            for (int i = 0; i < seg_count; i++) begin
                if (seg_busy[i] || seg_len[i] < size) continue;
                if (seg_len[i] == size) begin
                    seg_busy[i] = 1;
                    seg_owner[i] = job;
                    r.status = ST_OK;
                    r.start_address = seg_start[i];
                    return r;
                end
                if (seg_count >= NSEG) begin
                    r.status = ST_FULL;
                    return r;
                end
                for (int k = seg_count; k > i; k--) begin
                    seg_start[k] = seg_start[k-1];
                    seg_len[k] = seg_len[k-1];
                    seg_owner[k] = seg_owner[k-1];
                    seg_busy[k] = seg_busy[k-1];
                end
                seg_count++;
                seg_len[i] = size;
                seg_busy[i] = 1;
                seg_owner[i] = job;
                seg_start[i+1] = seg_start[i] + size;
                seg_len[i+1] = seg_len[i+1] - size;
                r.status = ST_OK;
                r.start_address = seg_start[i];
                return r;
            end
            return r;
        endfunction

        function t_rsp release_job(logic [7:0] job);
            t_rsp r;
            int k;
            k = find_job(job);
            r.start_address = '0;
            if (k < 0) begin
                r.status = ST_NOT_FOUND;
                return r;
            end
            r.status = ST_OK;
            seg_busy[k] = 0;
            if (k + 1 < seg_count && !seg_busy[k+1]) begin
                seg_len[k] = seg_len[k] + seg_len[k+1];
                shift_down(k + 1);
            end
            if (k > 0 && !seg_busy[k-1]) begin
                seg_len[k-1] = seg_len[k-1] + seg_len[k];
                shift_down(k);
            end
            return r;
        endfunction

        // Print one mismatch line and count it
        task report_mismatch(string what, int want, int got);
            $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
            errors++;
        endtask

        // Note an accepted request and queue its response
        function void note_request(t_req q);
            if (q.command == CMD_ALLOC) expected_rsp.push_back(allocate(q.job_id, q.request_size));
            else expected_rsp.push_back(release_job(q.job_id));
        endfunction

        // Compare an accepted response with the oldest expectation
        task check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                report_mismatch("response with no request pending", 0, int'(got.status));
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", int'(want.status), int'(got.status));
            if (got.start_address !== want.start_address)
                report_mismatch("start_address", int'(want.start_address),
                                int'(got.start_address));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    t_req        i_req = '0;
    logic        o_valid;
    logic        i_stall = 0;
    t_rsp        o_rsp;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    alloc_scoreboard sb = new();
    bit  hold_off = 0;

    first_fit_partition_allocator_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_req(i_req),
        .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Send one request, holding it until accepted
    task automatic send_request(logic cmd, logic [7:0] job, logic [15:0] size);
        t_req q;
        q.command = cmd;
        q.job_id = job;
        q.request_size = size;
        i_valid <= 1'b1;
        i_req <= q;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(q);
    endtask

    task automatic idle_gap(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Optional random sender gap after each burst of requests
    int burst_left = 0;
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
        end
    endtask

    // Drain outstanding responses, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic write_size(logic [15:0] size);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.init_table(size);
        @(posedge i_clk);
    endtask

    // Receiver: sample the response, stall on its own pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_response(o_rsp);
            stall_phase <= stall_phase + 1;
            if (hold_off) i_stall <= 1'b1;
            else if (stall_phase[8]) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Long receiver hold-off while the sender keeps offering requests
    initial begin
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Random phase: allocations, mostly of moderate size, and releases, mostly of known jobs
    task automatic random_phase(int count, logic [15:0] size, int job_span);
        logic [15:0] sz;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: sz = 16'($urandom);
                1: sz = 16'($urandom_range(0, 1));
                default: sz = 16'($urandom_range(1, (size >> 3) + 1));
            endcase
            if ($urandom_range(0, 9) < 5)
                send_request(CMD_ALLOC, 8'($urandom_range(0, job_span)), sz);
            else if ($urandom_range(0, 9) == 0)
                send_request(CMD_RELEASE, 8'($urandom), 16'($urandom));
            else
                send_request(CMD_RELEASE, 8'($urandom_range(0, job_span)), 16'($urandom));
            pace();
        end
    endtask

    initial begin
        sb.init_table(16'd4096);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: exact fit, zero request, duplicate, unknown job, merges, table full
        send_request(CMD_ALLOC, 8'd0, 16'd0);
        send_request(CMD_ALLOC, 8'd1, 16'd100);
        send_request(CMD_ALLOC, 8'd1, 16'd5);
        send_request(CMD_ALLOC, 8'd255, 16'hFFFF);
        send_request(CMD_RELEASE, 8'd77, 16'hFFFF);
        send_request(CMD_ALLOC, 8'd2, 16'd200);
        send_request(CMD_ALLOC, 8'd3, 16'd300);
        send_request(CMD_RELEASE, 8'd1, 16'd0);
        send_request(CMD_RELEASE, 8'd3, 16'd0);
        send_request(CMD_RELEASE, 8'd2, 16'd0);
        send_request(CMD_ALLOC, 8'd4, 16'd4096);
        send_request(CMD_RELEASE, 8'd4, 16'd0);
        for (int j = 10; j < 28; j++) send_request(CMD_ALLOC, j[7:0], 16'd1);
        drain();

        write_size(16'd0);
        send_request(CMD_ALLOC, 8'd5, 16'd1);
        send_request(CMD_RELEASE, 8'd5, 16'd1);
        drain();

        write_size(16'hFFFF);
        send_request(CMD_ALLOC, 8'hAA, 16'hFFFF);
        send_request(CMD_ALLOC, 8'h55, 16'd1);
        send_request(CMD_RELEASE, 8'hAA, 16'h0);
        drain();

        write_size(16'd1);
        random_phase(60, 16'd1, 7);
        drain();
        write_size(16'd4096);
        random_phase(400, 16'd4096, 24);
        drain();
        write_size(16'd40);
        random_phase(120, 16'd40, 15);
        drain();
        write_size(16'hFFFF);
        random_phase(150, 16'hFFFF, 255);
        drain();

        if (sb.errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
